[hw/rtl/ror_pkg.sv]
package ror_pkg;

  localparam int FUNC_W   = 1;
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 20;
  localparam int SLOT_W   = 4;
  localparam int BYTE_W   = 16;

  localparam logic [FUNC_W-1:0] FUNC_ADD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FIND = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   entry_address;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] lookup_offset;
  } ror_req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic [ADDR_W-1:0] found_address;
    logic [SIZE_W-1:0] found_size;
    logic [BYTE_W-1:0] byte_offset;
  } ror_rsp_t;

endpackage

[hw/rtl/ror_stream_if.sv]
interface ror_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/overwriting_ring_offset_lookup.sv]
// An add word gives no result.
// A find word walks one ring entry per cycle through the single compare and
// subtract unit, holding on its final entry until the result register is free.
// The result register lets the next word be accepted while a result waits.
// Synchronous active-high reset clears the ring pointers and the fill state;
// slots not yet written are skipped as empty by the valid check, without any clearing pass.
module overwriting_ring_offset_lookup #(
  parameter int SLOTS        = 16,
  parameter int SIZE_BITS    = 16,
  parameter int ADDRESS_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  ror_stream_if.sink   req,
  ror_stream_if.source rsp
);
  import ror_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state;

  logic [SW-1:0]       cur;
  logic [SW-1:0]       cnt;
  logic [OFFSET_W-1:0] rest;
  logic [SW-1:0]       cur_next;

  logic                    wr_en;
  logic [ADDRESS_BITS-1:0] wr_address;
  logic [SIZE_BITS-1:0]    wr_size;
  logic [SW-1:0]           rd_idx;
  logic [ADDRESS_BITS-1:0] rd_address;
  logic [SIZE_BITS-1:0]    rd_size;
  logic [SW-1:0]           write_slot;
  logic [SW-1:0]           read_slot;
  logic                    full;

  logic                entry_valid;
  logic                hit;
  logic [OFFSET_W-1:0] rest_next;
  logic                last;
  logic                finish;
  logic                can_finish;
  logic                req_fire;

  logic     rsp_valid;
  ror_rsp_t rsp_word;

  logic [ADDRESS_BITS+ADDR_W-1:0] addr_in_ext;
  logic [SIZE_BITS+SIZE_W-1:0]    size_in_ext;
  logic [SW+SLOT_W-1:0]           slot_out_ext;
  logic [ADDRESS_BITS+ADDR_W-1:0] addr_out_ext;
  logic [SIZE_BITS+SIZE_W-1:0]    size_out_ext;

  assign addr_in_ext  = {{ADDRESS_BITS{1'b0}}, req.payload.entry_address};
  assign size_in_ext  = {{SIZE_BITS{1'b0}}, req.payload.entry_size};
  assign slot_out_ext = {{SLOT_W{1'b0}}, cur};
  assign addr_out_ext = {{ADDR_W{1'b0}}, rd_address};
  assign size_out_ext = {{SIZE_W{1'b0}}, rd_size};

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign wr_en     = req_fire && (req.payload.func == FUNC_ADD);
  assign wr_address = addr_in_ext[ADDRESS_BITS-1:0];
  assign wr_size    = size_in_ext[SIZE_BITS-1:0];

  assign cur_next    = (cur == LAST) ? '0 : cur + SW'(1);
  assign entry_valid = full || (cur < write_slot);
  assign last        = (cnt == LAST) || (!full && (cur_next >= write_slot));
  assign finish      = hit || last;
  assign can_finish  = !rsp_valid || rsp.ready;

  always_comb begin
    rd_idx = read_slot;
    if (state == ST_WALK) begin
      rd_idx = (finish && !can_finish) ? cur : cur_next;
    end
  end

  ror_ring #(
    .SLOTS        (SLOTS),
    .SIZE_BITS    (SIZE_BITS),
    .ADDRESS_BITS (ADDRESS_BITS),
    .SW           (SW)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_address (wr_address),
    .wr_size    (wr_size),
    .rd_idx     (rd_idx),
    .rd_address (rd_address),
    .rd_size    (rd_size),
    .write_slot (write_slot),
    .read_slot  (read_slot),
    .full       (full)
  );

  ror_walk_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_walk (
    .rest        (rest),
    .size        (rd_size),
    .entry_valid (entry_valid),
    .hit         (hit),
    .rest_next   (rest_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == ST_WALK) && finish && can_finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_fire && (req.payload.func == FUNC_FIND)) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (finish && can_finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      cur  <= read_slot;
      cnt  <= '0;
      rest <= req.payload.lookup_offset;
    end else if (!finish) begin
      cur  <= cur_next;
      cnt  <= cnt + SW'(1);
      rest <= rest_next;
    end
    if ((state == ST_WALK) && finish && can_finish) begin
      rsp_word.found         <= hit;
      rsp_word.found_slot    <= hit ? slot_out_ext[SLOT_W-1:0] : '0;
      rsp_word.found_address <= hit ? addr_out_ext[ADDR_W-1:0] : '0;
      rsp_word.found_size    <= hit ? size_out_ext[SIZE_W-1:0] : '0;
      rsp_word.byte_offset   <= hit ? rest[BYTE_W-1:0] : '0;
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.payload = rsp_word;

`ifndef SYNTHESIS
  a_find_starts_walk: assert property (@(posedge clk) disable iff (rst)
    req_fire && (req.payload.func == FUNC_FIND) |=> state == ST_WALK)
    else $error("accepted find did not start a walk");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_word.found |->
      rsp_word.found_slot == '0 && rsp_word.found_address == '0 &&
      rsp_word.found_size == '0 && rsp_word.byte_offset == '0)
    else $error("not-found result carries nonzero fields");
`endif

endmodule

[hw/rtl/ror_ring.sv]
module ror_ring #(
  parameter int SLOTS        = 16,
  parameter int SIZE_BITS    = 16,
  parameter int ADDRESS_BITS = 32,
  parameter int SW           = $clog2(SLOTS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [ADDRESS_BITS-1:0] wr_address,
  input  logic [SIZE_BITS-1:0]    wr_size,
  input  logic [SW-1:0]           rd_idx,
  output logic [ADDRESS_BITS-1:0] rd_address,
  output logic [SIZE_BITS-1:0]    rd_size,
  output logic [SW-1:0]           write_slot,
  output logic [SW-1:0]           read_slot,
  output logic                    full
);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  logic [ADDRESS_BITS-1:0] mem_address [SLOTS];
  logic [SIZE_BITS-1:0]    mem_size    [SLOTS];

  logic [SW-1:0] write_slot_next;
  logic [SW-1:0] read_slot_next;

  assign write_slot_next = (write_slot == LAST) ? '0 : write_slot + SW'(1);
  assign read_slot_next  = (read_slot == LAST) ? '0 : read_slot + SW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_address[write_slot] <= wr_address;
      mem_size[write_slot]    <= wr_size;
    end
    rd_address <= mem_address[rd_idx];
    rd_size    <= mem_size[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      read_slot  <= '0;
      full       <= 1'b0;
    end else if (wr_en) begin
      write_slot <= write_slot_next;
      if (full) begin
        read_slot <= read_slot_next;
      end else if (write_slot == LAST) begin
        full <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_read_at_zero_until_full: assert property (@(posedge clk) disable iff (rst)
    !full |-> read_slot == '0)
    else $error("read slot moved before the ring was full");

  a_slots_meet_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> write_slot == read_slot)
    else $error("write and read slots differ in a full ring");
`endif

endmodule

[hw/rtl/ror_walk_unit.sv]
module ror_walk_unit #(
  parameter int SIZE_BITS = 16
) (
  input  logic [ror_pkg::OFFSET_W-1:0] rest,
  input  logic [SIZE_BITS-1:0]         size,
  input  logic                         entry_valid,
  output logic                         hit,
  output logic [ror_pkg::OFFSET_W-1:0] rest_next
);
  import ror_pkg::*;

  localparam int CW = (SIZE_BITS > OFFSET_W) ? SIZE_BITS : OFFSET_W;

  logic [CW-1:0] rest_ext;
  logic [CW-1:0] size_ext;
  logic [CW-1:0] diff;

  assign rest_ext = CW'(rest);
  assign size_ext = CW'(size);
  assign diff     = rest_ext - size_ext;

  assign hit       = entry_valid && (rest_ext < size_ext);
  assign rest_next = entry_valid ? diff[OFFSET_W-1:0] : rest;

endmodule

[dv/overwriting_ring_offset_lookup_test.sv]
module overwriting_ring_offset_lookup_test;
  import ror_pkg::*;

  localparam int RING_SLOTS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = RING_SLOTS + 8;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  class ring_lookup_scoreboard;
    logic [ADDR_W-1:0] slot_addr [RING_SLOTS];
    logic [SIZE_W-1:0] slot_len [RING_SLOTS];
    int unsigned wr_slot;
    int unsigned rd_slot;
    bit full;
    ror_rsp_t lookup_q[$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < RING_SLOTS; i++) begin
        slot_addr[i] = '0;
        slot_len[i] = '0;
      end
      wr_slot = 0;
      rd_slot = 0;
      full = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return lookup_q.size();
    endfunction

    function int unsigned stored_bytes();
      int unsigned sum;
      sum = 0;
      for (int i = 0; i < RING_SLOTS; i++) sum += 32'(slot_len[i]);
      return sum;
    endfunction

    function void note_request(ror_req_t w);
      ror_rsp_t res;
      int unsigned rest;
      int unsigned s;
      bit hit;
      if (w.func == FUNC_ADD) begin
        slot_addr[wr_slot] = w.entry_address;
        slot_len[wr_slot] = w.entry_size;
        if (full) begin
          rd_slot = (rd_slot + 1) % RING_SLOTS;
        end else if (wr_slot == RING_SLOTS - 1) begin
          full = 1'b1;
        end
        wr_slot = (wr_slot + 1) % RING_SLOTS;
      end else begin
        res = '0;
        rest = 32'(w.lookup_offset);
        s = rd_slot;
        hit = 1'b0;
        for (int i = 0; i < RING_SLOTS; i++) begin
          if (!hit) begin
            if (rest < 32'(slot_len[s])) begin
              hit = 1'b1;
              res.found = 1'b1;
              res.found_slot = s[SLOT_W-1:0];
              res.found_address = slot_addr[s];
              res.found_size = slot_len[s];
              res.byte_offset = rest[BYTE_W-1:0];
            end else begin
              rest -= 32'(slot_len[s]);
              s = (s + 1) % RING_SLOTS;
            end
          end
        end
        lookup_q.push_back(res);
      end
    endfunction

    function void check_response(ror_rsp_t got);
      ror_rsp_t exp;
      if (lookup_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b slot=%0d addr=%h size=%h offset=%h",
                   got.found, got.found_slot, got.found_address, got.found_size,
                   got.byte_offset);
      end else begin
        exp = lookup_q.pop_front();
        if (got.found !== exp.found || got.found_slot !== exp.found_slot ||
            got.found_address !== exp.found_address || got.found_size !== exp.found_size ||
            got.byte_offset !== exp.byte_offset) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch expected: found=%0b slot=%0d addr=%h size=%h offset=%h",
                     exp.found, exp.found_slot, exp.found_address, exp.found_size,
                     exp.byte_offset);
            $display("mismatch actual:   found=%0b slot=%0d addr=%h size=%h offset=%h",
                     got.found, got.found_slot, got.found_address, got.found_size,
                     got.byte_offset);
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ror_stream_if #(.T(ror_req_t)) req_if ();
  ror_stream_if #(.T(ror_rsp_t)) rsp_if ();

  ring_lookup_scoreboard sb;
  int unsigned cycle_count;
  int unsigned hold_request;
  bit src_idle_on;
  bit rsp_idle_on;

  overwriting_ring_offset_lookup #(
    .SLOTS(RING_SLOTS),
    .SIZE_BITS(SIZE_W),
    .ADDRESS_BITS(ADDR_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("overwriting_ring_offset_lookup verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.payload);
      if (req_if.valid && req_if.ready) sb.note_request(req_if.payload);
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (rsp_idle_on && $urandom_range(0, 99) < 21) begin
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input ror_req_t w);
    @(negedge clk);
    while (src_idle_on && $urandom_range(0, 99) < 21) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.payload <= w;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic send_add(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] len);
    ror_req_t w;
    w.func = FUNC_ADD;
    w.entry_address = addr;
    w.entry_size = len;
    w.lookup_offset = OFFSET_W'($urandom);
    send_word(w);
  endtask

  task automatic send_find(input logic [OFFSET_W-1:0] offset);
    ror_req_t w;
    w.func = FUNC_FIND;
    w.entry_address = $urandom;
    w.entry_size = SIZE_W'($urandom);
    w.lookup_offset = offset;
    send_word(w);
  endtask

  task automatic send_random(input int unsigned find_pct);
    int unsigned pick;
    int unsigned stored;
    logic [SIZE_W-1:0] len;
    if ($urandom_range(0, 99) < find_pct) begin
      stored = sb.stored_bytes();
      if (stored > 32'(OFFSET_MAX)) stored = 32'(OFFSET_MAX);
      if (stored > 0 && $urandom_range(0, 99) < 70)
        send_find(OFFSET_W'($urandom_range(0, stored)));
      else send_find(OFFSET_W'($urandom));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10) len = '0;
      else if (pick < 50) len = SIZE_W'($urandom_range(1, 15));
      else if (pick < 80) len = SIZE_W'($urandom_range(0, 255));
      else len = SIZE_W'($urandom);
      send_add($urandom, len);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    hold_request = 0;
    src_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An empty ring holds no bytes at all, so even the largest offset misses.
    send_find(OFFSET_MAX);
    send_add('0, '0);
    send_add('1, '1);
    send_add($urandom, 16'd1);
    send_find('0);
    send_find(20'h0FFFF);
    send_find(20'h10000);
    // These adds wrap the ring and overwrite the oldest entry.
    for (int i = 0; i < 14; i++) send_add($urandom, '1);
    send_find(OFFSET_MAX);
    send_find(20'hFFFEF);

    for (int i = 0; i < 150; i++) send_random(55);

    src_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    for (int i = 0; i < 100; i++) send_random(55);

    // The receiver holds off while finds keep coming, so the block backs up.
    hold_request = 300;
    for (int i = 0; i < 40; i++) send_random(100);
    @(negedge clk);
    req_if.valid <= 1'b0;
    wait_drained();

    src_idle_on = 1'b1;
    rsp_idle_on = 1'b1;
    for (int i = 0; i < 160; i++) send_random(55);

    @(negedge clk);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("overwriting_ring_offset_lookup verification clean");
    end else begin
      $display("overwriting_ring_offset_lookup verification failed");
    end
    $finish;
  end
endmodule
